### hw/rtl/assert_macros.svh
// Assertion macros used by the PID controller top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that an active-low reset disables.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/pidm_pkg.sv
// Package with the constants, codes and saturation helpers of the PID block.
package pidm_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int DECAY_FACTOR_DEF = 65470;
    localparam int DECAY_SHIFT      = 16;
    localparam int DIV_STEPS        = 64;
    localparam int PADDR_W          = 5;

    localparam logic [1:0] OP_PLAIN  = 2'd0;
    localparam logic [1:0] OP_AW     = 2'd1;
    localparam logic [1:0] OP_MANUAL = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] REG_SETPOINT = 3'd0;
    localparam logic [2:0] REG_GAIN_P   = 3'd1;
    localparam logic [2:0] REG_GAIN_I   = 3'd2;
    localparam logic [2:0] REG_GAIN_D   = 3'd3;
    localparam logic [2:0] REG_OUT_LOW  = 3'd4;
    localparam logic [2:0] REG_OUT_HIGH = 3'd5;
    localparam logic [2:0] REG_FB_SCALE = 3'd6;
    localparam logic [2:0] REG_MODE     = 3'd7;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Clamp to the output limits; the low limit is tested first.
    function automatic logic signed [31:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        logic signed [31:0] r;
        if (v < 64'(lo)) begin
            r = lo;
        end else if (v > 64'(hi)) begin
            r = hi;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/pidm_in_if.sv
// Input channel: one request word per handshake.
interface pidm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [31:0] sample;
    logic [30:0]        sample_period;
    logic signed [31:0] manual_value;

    modport source (output valid, opcode, sample, sample_period, manual_value, input ready);
    modport sink   (input valid, opcode, sample, sample_period, manual_value, output ready);
endinterface

### hw/rtl/pidm_out_if.sv
// Output channel: one result word per handshake.
interface pidm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic signed [31:0] error_now;

    modport source (output valid, drive, error_now, input ready);
    modport sink   (input valid, drive, error_now, output ready);
endinterface

### hw/rtl/pidm_mul.sv
// Shared 32 by 32 signed multiplier with a registered 64-bit product.
module pidm_mul
    import pidm_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_prod
);

    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

### hw/rtl/pidm_div.sv
// Bit-serial signed divider of a 64-bit dividend by a 31-bit period.
module pidm_div
    import pidm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_dividend,
    input  logic [30:0]        i_divisor,
    output logic               o_done,
    output logic signed [31:0] o_quot
);

    localparam int          CNT_W    = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [63:0]      r_quo;
    logic [30:0]      r_dvs;
    logic             r_neg;

    logic [31:0] rem_sh;
    logic        ge;
    logic [63:0] lim_neg;

    assign rem_sh  = {r_rem[30:0], r_quo[63]};
    assign ge      = rem_sh >= {1'b0, r_dvs};
    assign lim_neg = 64'h0000_0000_8000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_neg  <= i_dividend[63];
                r_quo  <= i_dividend[63] ? 64'(64'd0 - 64'(i_dividend)) : 64'(i_dividend);
            end else if (r_busy) begin
                r_rem <= ge ? rem_sh - {1'b0, r_dvs} : rem_sh;
                r_quo <= {r_quo[62:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            o_quot = (r_quo > lim_neg) ? 32'sh80000000 : 32'(32'd0 - r_quo[31:0]);
        end else begin
            o_quot = (r_quo > 64'h0000_0000_7fff_ffff) ? 32'sh7fffffff : r_quo[31:0];
        end
    end

    assign o_done = r_done;

endmodule

### hw/rtl/pid_controller_modes.sv
// Top level of the fixed-point PID controller with its sequencer and register file.
// One request word at a time is taken and worked through a small sequencer that
// shares a single registered 32 by 32 multiplier; the block is not ready until the
// result word has been handed to the output register. A manual or unused request
// goes straight to the finishing and emit states; normalized mode adds a multiply
// to a step, and integral decay adds a decay multiply to a positional plain step
// when it fires. An incremental anti-windup step adds the bit-serial divider,
// which retires one quotient bit per cycle. A stalled output holds the sequencer
// in its emit state for as long as it lasts. Values are signed Q16.16 and saturate
// to 32 bits; the limits clamp both the output and the integral. Where the limits
// cross, a value below the low limit gives the low limit and any other the high.
// Registers are written through the APB port at byte address 4*i; the user must
// write them only while idle, which the block itself does not enforce.
`include "assert_macros.svh"
module pid_controller_modes
    import pidm_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int DECAY_FACTOR = DECAY_FACTOR_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pidm_in_if.sink            i_in,
    pidm_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_ERR, S_MP, S_MI, S_MT, S_MTP, S_MD0, S_MD1,
        S_DIV, S_FIN, S_DECM, S_DECW, S_EMIT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic signed [31:0] r_sp, r_kp, r_ki, r_kd, r_lo, r_hi, r_fs;
    logic [2:0]         r_mode;

    // Controller state.
    logic signed [31:0] r_int, r_hold, r_e1, r_e2;

    // Latched request and working terms.
    logic [1:0]         r_op;
    logic signed [31:0] r_smp, r_man;
    logic [30:0]        r_per;
    logic signed [31:0] r_err, r_tp, r_ti, r_td;

    // Output register.
    logic               r_ovalid;
    logic signed [31:0] r_drive, r_oerr;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    logic               div_start, div_done;
    logic signed [31:0] div_quot;

    logic signed [31:0] q, perr, derr, isum, vs;
    logic signed [63:0] vc;
    logic               incr, aw, dec_hit;

    assign incr = r_mode[1];
    assign aw   = (r_op == OP_AW);

    assign q    = sat64(prod >>> FRAC_BITS);
    assign perr = sat64(64'(r_err) - 64'(r_e1));
    assign derr = sat64(64'(r_err) - (64'(r_e1) <<< 1) + 64'(r_e2));

    // Positional update terms, used in the finishing state.
    assign isum    = sat64(64'(r_int) + 64'(r_ti));
    assign vc      = aw ? 64'(r_tp) + 64'(isum) : 64'(r_tp) + 64'(isum) + 64'(r_td);
    assign vs      = clamp64(vc, r_lo, r_hi);
    assign dec_hit = ((vc > 64'(r_hi)) || (vc < 64'(r_lo))) && r_mode[2];

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_NORM: begin
                mul_a = r_smp;
                mul_b = r_fs;
            end
            S_MP: begin
                mul_a = r_kp;
                mul_b = incr ? perr : r_err;
            end
            S_MI: begin
                mul_a = r_ki;
                mul_b = r_err;
            end
            S_MT: begin
                mul_a = q;
                mul_b = {1'b0, r_per};
            end
            S_MD0: begin
                mul_a = r_kd;
                mul_b = incr ? derr : perr;
            end
            S_DECM: begin
                mul_a = r_int;
                mul_b = 32'(DECAY_FACTOR);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_start = (r_state == S_MD1) && incr && aw;

    pidm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    pidm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod),
        .i_divisor  (r_per),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Sequencer, controller state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_int    <= '0;
            r_hold   <= '0;
            r_e1     <= '0;
            r_e2     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // The emit state decides the output valid itself while it is active.
            if (o_out.ready && r_state != S_EMIT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op  <= i_in.opcode;
                        r_smp <= i_in.sample;
                        r_man <= i_in.manual_value;
                        r_per <= (i_in.sample_period == '0) ? 31'd1 : i_in.sample_period;
                        r_err <= '0;
                        if (i_in.opcode == OP_PLAIN || i_in.opcode == OP_AW) begin
                            r_state <= r_mode[0] ? S_NORM : S_ERR;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_NORM: begin
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_err   <= r_mode[0] ? sat64(ONE_Q - 64'(q))
                                         : sat64(64'(r_sp) - 64'(r_smp));
                    r_state <= S_MP;
                end
                S_MP: begin
                    r_state <= S_MI;
                end
                S_MI: begin
                    r_tp    <= q;
                    r_state <= S_MT;
                end
                S_MT: begin
                    r_ti    <= q;
                    r_state <= aw ? S_MTP : S_MD0;
                end
                S_MTP: begin
                    r_ti    <= q;
                    r_state <= incr ? S_MD0 : S_FIN;
                end
                S_MD0: begin
                    r_state <= S_MD1;
                end
                S_MD1: begin
                    r_td <= q;
                    r_state <= (incr && aw) ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_td    <= div_quot;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Only a positional plain step that leaves the limits with decay on
                    // goes through the decay multiply.
                    r_state <= (r_op == OP_PLAIN && !incr && dec_hit) ? S_DECM : S_EMIT;
                    if (r_op == OP_MANUAL) begin
                        r_hold <= clamp64(64'(r_man), r_lo, r_hi);
                        r_e1   <= '0;
                        r_e2   <= '0;
                    end else if (r_op == OP_PLAIN || r_op == OP_AW) begin
                        r_e2 <= r_e1;
                        r_e1 <= r_err;
                        if (incr) begin
                            r_hold <= clamp64(64'(r_hold) + 64'(r_tp) + 64'(r_ti)
                                              + 64'(r_td), r_lo, r_hi);
                        end else if (aw) begin
                            r_hold <= vs;
                            r_int  <= clamp64(64'(sat64(64'(isum) - (vc - 64'(vs)))),
                                              r_lo, r_hi);
                        end else begin
                            r_hold <= vs;
                            if (!dec_hit) begin
                                r_int <= clamp64(64'(isum), r_lo, r_hi);
                            end
                        end
                    end
                end
                S_DECM: begin
                    r_state <= S_DECW;
                end
                S_DECW: begin
                    r_int   <= clamp64(prod >>> DECAY_SHIFT, r_lo, r_hi);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_drive  <= r_hold;
                        r_oerr   <= r_err;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.drive     = r_drive;
    assign o_out.error_now = r_oerr;

    // Register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= 32'(ONE_Q);
            r_kp   <= '0;
            r_ki   <= '0;
            r_kd   <= '0;
            r_lo   <= '0;
            r_hi   <= '0;
            r_fs   <= 32'(ONE_Q);
            r_mode <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[PADDR_W-1:2])
                REG_SETPOINT: r_sp   <= pwdata;
                REG_GAIN_P:   r_kp   <= pwdata;
                REG_GAIN_I:   r_ki   <= pwdata;
                REG_GAIN_D:   r_kd   <= pwdata;
                REG_OUT_LOW:  r_lo   <= pwdata;
                REG_OUT_HIGH: r_hi   <= pwdata;
                REG_FB_SCALE: r_fs   <= pwdata;
                REG_MODE:     r_mode <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[PADDR_W-1:2])
            REG_SETPOINT: prdata = r_sp;
            REG_GAIN_P:   prdata = r_kp;
            REG_GAIN_I:   prdata = r_ki;
            REG_GAIN_D:   prdata = r_kd;
            REG_OUT_LOW:  prdata = r_lo;
            REG_OUT_HIGH: prdata = r_hi;
            REG_FB_SCALE: prdata = r_fs;
            REG_MODE:     prdata = {29'd0, r_mode};
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // An accepted request always starts the sequencer.
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> (r_state != S_IDLE), "accepted request left the sequencer idle")
    // The divider only finishes while the sequencer waits for it.
    `ASSERT_CLK(a_div_wait, i_clk, i_rst_n, div_done |-> (r_state == S_DIV), "divider finished outside its wait state")
    // A result word appears only from the emit state.
    `ASSERT_CLK(a_emit_src, i_clk, i_rst_n, $rose(r_ovalid) |-> ($past(r_state) == S_EMIT), "result word raised outside the emit state")

endmodule
